// File: hdl/bmsa_pkg.sv
// Shared types and constants for the binned mean-square accumulator.
// No dependencies; imported by every module of the block but bmsa_ram.
`default_nettype none
package bmsa_pkg;
  localparam int NUM_BINS = 64;
  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int SUM_W = 48;
  localparam int CNT_W = 32;
  localparam int SQ_W = 31;
  localparam int MEAN_W = 32;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic KIND_ACC = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Command passed from the front part to the back part.
  typedef struct packed {
    logic             rd;
    logic             cis_ok;
    logic             trans_ok;
    logic [BIN_W-1:0] cis_bin;
    logic [BIN_W-1:0] trans_bin;
    logic [SQ_W-1:0]  cis_sq_x, cis_sq_y, cis_sq_z;
    logic [SQ_W-1:0]  trans_sq_x, trans_sq_y, trans_sq_z;
  } cmd_t;

  // Square of a 16-bit two's complement value (magnitude squared).
  function automatic logic [SQ_W-1:0] square16(input logic signed [15:0] v);
    logic [16:0] mag;
    logic [33:0] p;
    mag = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
    p = mag * mag;
    return p[SQ_W-1:0];
  endfunction
endpackage
`default_nettype wire

// File: hdl/bmsa_front.sv
// Front part: accepts items, checks bin ranges, squares the components
// and pushes one command a beat, while not full, into a short queue. Depends on bmsa_pkg.
`default_nettype none
module bmsa_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  output logic                 full,
  input  wire                  kind,
  input  wire signed [15:0]    cis_x, cis_y, cis_z,
  input  wire signed [15:0]    trans_x, trans_y, trans_z,
  input  wire [7:0]            cis_bin,
  input  wire [7:0]            trans_bin,
  input  wire [5:0]            read_bin,
  output bmsa_pkg::cmd_t       cmd,
  output logic                 cmd_valid,
  input  wire                  cmd_take
);
  import bmsa_pkg::*;

  cmd_t q [QDEPTH];
  logic [QPTR_W-1:0] rd_ptr, wr_ptr;
  logic [QPTR_W:0] count;
  cmd_t c_in;
  logic do_push, do_pop;
  logic [5:0] rb;

  assign full = (count == (QPTR_W+1)'(QDEPTH));
  assign do_push = push && !full;
  assign cmd_valid = (count != '0);
  assign do_pop = cmd_take && cmd_valid;
  assign cmd = q[rd_ptr];
  assign rb = read_bin;

  // Classify the item and square its components
  always_comb begin
    c_in = '0;
    c_in.rd = (kind == KIND_READ);
    if (kind == KIND_READ) begin
      c_in.cis_ok = (32'(rb) < NUM_BINS);
      c_in.trans_ok = c_in.cis_ok;
      c_in.cis_bin = BIN_W'(rb);
      c_in.trans_bin = BIN_W'(rb);
    end else begin
      c_in.cis_ok = (cis_bin >= 8'd2) && (32'(cis_bin) < NUM_BINS);
      c_in.trans_ok = (trans_bin >= 8'd2) && (32'(trans_bin) < NUM_BINS);
      c_in.cis_bin = BIN_W'(cis_bin);
      c_in.trans_bin = BIN_W'(trans_bin);
    end
    c_in.cis_sq_x = square16(cis_x);
    c_in.cis_sq_y = square16(cis_y);
    c_in.cis_sq_z = square16(cis_z);
    c_in.trans_sq_x = square16(trans_x);
    c_in.trans_sq_y = square16(trans_y);
    c_in.trans_sq_z = square16(trans_z);
  end

  // Hold commands in the queue
  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= c_in;
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH)) else $error("queue overflow");
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    full && !do_pop |=> full) else $error("full dropped without pop");
  a_empty_stays: assert property (@(posedge clk) disable iff (rst)
    !cmd_valid && !do_push |=> !cmd_valid) else $error("phantom command");
endmodule
`default_nettype wire

// File: hdl/bmsa_div.sv
// Iterative 48-by-32 divider, one quotient bit a cycle, saturated to 32 bits.
// Depends on bmsa_pkg.
`default_nettype none
module bmsa_div (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire [bmsa_pkg::SUM_W-1:0]    num,
  input  wire [bmsa_pkg::CNT_W-1:0]    den,
  output logic                         busy,
  output logic [bmsa_pkg::MEAN_W-1:0]  quo
);
  import bmsa_pkg::*;

  logic [SUM_W-1:0] q;
  logic [CNT_W:0] rem;
  logic [CNT_W-1:0] d;
  logic [5:0] n;
  logic [CNT_W:0] trial;
  logic [CNT_W:0] sh;

  assign sh = {rem[CNT_W-1:0], q[SUM_W-1]};
  assign trial = sh - {1'b0, d};
  assign quo = (q[SUM_W-1:MEAN_W] != '0) ? {MEAN_W{1'b1}} : q[MEAN_W-1:0];

  // Shift in one numerator bit and subtract where it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      n <= '0;
    end else if (start) begin
      busy <= 1'b1;
      q <= num;
      rem <= '0;
      d <= den;
      n <= 6'(SUM_W);
    end else if (busy) begin
      if (!trial[CNT_W]) begin
        rem <= trial;
        q <= {q[SUM_W-2:0], 1'b1};
      end else begin
        rem <= sh;
        q <= {q[SUM_W-2:0], 1'b0};
      end
      n <= n - 1'b1;
      if (n == 6'd1) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// File: hdl/bmsa_back.sv
// Generic registered-read RAM, and the back part: read-modify-write of the
// per-bin sums and counts, and readout of six means with a shared divider.
// Depends on bmsa_pkg, bmsa_div.
`default_nettype none
module bmsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire                      rd_en,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, register one read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end
endmodule

module bmsa_back (
  input  wire                          clk,
  input  wire                          rst,
  input  wire bmsa_pkg::cmd_t          cmd,
  input  wire                          cmd_valid,
  output logic                         cmd_take,
  output logic                         empty,
  input  wire                          pop,
  output logic                         cis_present,
  output logic [31:0]                  cis_mean_x, cis_mean_y, cis_mean_z,
  output logic                         trans_present,
  output logic [31:0]                  trans_mean_x, trans_mean_y, trans_mean_z
);
  import bmsa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ACC, S_LOAD, S_DIV_GO, S_DIV_WAIT, S_OUT
  } state_t;

  // One word per bin and channel: count and the x, y, z square sums
  typedef struct packed {
    logic [CNT_W-1:0]            cnt;
    logic [2:0][SUM_W-1:0]       sum;
  } bin_t;

  state_t state;
  cmd_t hold;
  logic [BIN_W-1:0] clr;
  logic [2:0] lane;
  logic [SUM_W-1:0] rs [6];
  logic [CNT_W-1:0] rc, rt;
  logic okc, okt;
  logic [MEAN_W-1:0] res [6];
  logic div_start, div_busy;
  logic [MEAN_W-1:0] quo;
  logic [SUM_W-1:0] div_num;
  logic [CNT_W-1:0] div_den;
  logic [SQ_W-1:0] sq [6];
  logic [SUM_W:0] add [6];
  logic rd_en;
  logic c_we, t_we;
  logic [BIN_W-1:0] c_waddr, t_waddr;
  bin_t c_wr, t_wr, c_rd, t_rd;

  assign sq[0] = hold.cis_sq_x;
  assign sq[1] = hold.cis_sq_y;
  assign sq[2] = hold.cis_sq_z;
  assign sq[3] = hold.trans_sq_x;
  assign sq[4] = hold.trans_sq_y;
  assign sq[5] = hold.trans_sq_z;

  assign cmd_take = cmd_valid && (state == S_IDLE);
  assign rd_en = cmd_take;
  assign empty = (state != S_OUT);
  assign div_start = (state == S_DIV_GO);
  assign div_num = rs[lane];
  assign div_den = (lane < 3'd3) ? rc : rt;

  // Carry-extended adds for the six lanes, saturated on write-back
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      add[i] = {1'b0, c_rd.sum[i]} + (SUM_W+1)'(sq[i]);
      add[i+3] = {1'b0, t_rd.sum[i]} + (SUM_W+1)'(sq[i+3]);
    end
  end

  // Write back an accumulated bin, or zero one bin during the clearing pass
  always_comb begin
    c_we = 1'b0;
    t_we = 1'b0;
    c_waddr = clr;
    t_waddr = clr;
    c_wr = '0;
    t_wr = '0;
    if (state == S_CLEAR) begin
      c_we = 1'b1;
      t_we = 1'b1;
    end else if (state == S_ACC) begin
      c_we = hold.cis_ok;
      t_we = hold.trans_ok;
      c_waddr = hold.cis_bin;
      t_waddr = hold.trans_bin;
      for (int i = 0; i < 3; i++) begin
        c_wr.sum[i] = add[i][SUM_W] ? SUM_MAX : add[i][SUM_W-1:0];
        t_wr.sum[i] = add[i+3][SUM_W] ? SUM_MAX : add[i+3][SUM_W-1:0];
      end
      c_wr.cnt = (c_rd.cnt != CNT_MAX) ? c_rd.cnt + 1'b1 : c_rd.cnt;
      t_wr.cnt = (t_rd.cnt != CNT_MAX) ? t_rd.cnt + 1'b1 : t_rd.cnt;
    end
  end

  bmsa_ram #(.WIDTH($bits(bin_t)), .DEPTH(NUM_BINS)) u_cis_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wr),
    .rd_en(rd_en), .raddr(cmd.cis_bin), .rdata(c_rd)
  );

  bmsa_ram #(.WIDTH($bits(bin_t)), .DEPTH(NUM_BINS)) u_trans_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wr),
    .rd_en(rd_en), .raddr(cmd.trans_bin), .rdata(t_rd)
  );

  bmsa_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(quo)
  );

  // Sequence clear, accumulate and readout
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      lane <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == BIN_W'(NUM_BINS-1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            hold <= cmd;
            state <= cmd.rd ? S_LOAD : S_ACC;
          end
        end
        S_ACC: begin
          state <= S_IDLE;
        end
        S_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            rs[i] <= c_rd.sum[i];
            rs[i+3] <= t_rd.sum[i];
          end
          rc <= c_rd.cnt;
          rt <= t_rd.cnt;
          okc <= hold.cis_ok && (c_rd.cnt != '0);
          okt <= hold.trans_ok && (t_rd.cnt != '0);
          lane <= '0;
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          if ((lane < 3'd3) ? okc : okt) state <= S_DIV_WAIT;
          else begin
            res[lane] <= '0;
            if (lane == 3'd5) state <= S_OUT;
            else lane <= lane + 1'b1;
          end
        end
        S_DIV_WAIT: begin
          if (!div_busy) begin
            res[lane] <= quo;
            if (lane == 3'd5) state <= S_OUT;
            else begin
              lane <= lane + 1'b1;
              state <= S_DIV_GO;
            end
          end
        end
        S_OUT: begin
          if (pop) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cis_present = okc;
  assign trans_present = okt;
  assign cis_mean_x = res[0];
  assign cis_mean_y = res[1];
  assign cis_mean_z = res[2];
  assign trans_mean_x = res[3];
  assign trans_mean_y = res[4];
  assign trans_mean_z = res[5];

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !cmd_take) else $error("command taken while busy");
  a_acc_two_cycles: assert property (@(posedge clk) disable iff (rst)
    state == S_ACC |=> state == S_IDLE) else $error("accumulate overran");
  a_res_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && !pop |=> state == S_OUT && $stable(res[0]))
    else $error("result changed while stalled");
  a_empty_mean: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && !okc |-> res[0] == '0) else $error("empty bin mean");
endmodule
`default_nettype wire

// File: hdl/binned_mean_square_accumulator_core.sv
// Top level of the binned mean-square accumulator: front part and back part.
// Depends on bmsa_pkg, bmsa_front, bmsa_back.
//
// Input channel: push/full. kind 0 accumulates the squares of each channel's
// vector into its bin (bins 2..NUM_BINS-1, others ignored); kind 1 reads bin
// read_bin. A four-entry command queue parts the front and the back.
// Result channel: empty/pop, one beat per readout, none per accumulate.
// Accumulate: the back reads the bin words as it takes the command, then
// writes them back in S_ACC, and takes no new command before it is through;
// the queue absorbs short bursts and full rises when it fills.
// Readout: S_LOAD registers the bin words, then the shared divider computes
// the means lane by lane (S_DIV_GO starts it, S_DIV_WAIT takes the quotient);
// a lane of an empty channel is set to zero in S_DIV_GO without a divide;
// the back then holds the result until popped and takes no further command
// meanwhile, and the queue fills, raising full.
// Reset: a clearing pass through all NUM_BINS bins zeroes the stores; items are
// queued meanwhile and processed once it ends.
`default_nettype none
module binned_mean_square_accumulator_core (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  output logic             full,
  input  wire              kind,
  input  wire signed [15:0] cis_x, cis_y, cis_z,
  input  wire signed [15:0] trans_x, trans_y, trans_z,
  input  wire [7:0]        cis_bin,
  input  wire [7:0]        trans_bin,
  input  wire [5:0]        read_bin,
  output logic             empty,
  input  wire              pop,
  output logic             cis_present,
  output logic [31:0]      cis_mean_x, cis_mean_y, cis_mean_z,
  output logic             trans_present,
  output logic [31:0]      trans_mean_x, trans_mean_y, trans_mean_z
);
  import bmsa_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_take;

  bmsa_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind),
    .cis_x(cis_x), .cis_y(cis_y), .cis_z(cis_z),
    .trans_x(trans_x), .trans_y(trans_y), .trans_z(trans_z),
    .cis_bin(cis_bin), .trans_bin(trans_bin), .read_bin(read_bin),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
  );

  bmsa_back u_back (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .empty(empty), .pop(pop),
    .cis_present(cis_present), .cis_mean_x(cis_mean_x),
    .cis_mean_y(cis_mean_y), .cis_mean_z(cis_mean_z),
    .trans_present(trans_present), .trans_mean_x(trans_mean_x),
    .trans_mean_y(trans_mean_y), .trans_mean_z(trans_mean_z)
  );
endmodule
`default_nettype wire
